/* sv/prac_pkg.sv */
// Shared widths, types and constants for the point rotation pipeline.
package prac_pkg;

	localparam int COORD_WIDTH    = 24;
	localparam int ROTATION_STEPS = 16;
	localparam int GUARD          = 16;
	localparam int ANGLE_W        = 16;
	localparam int Z_W            = 32;
	localparam int OFF_W          = COORD_WIDTH + 2;
	localparam int CORD_W         = (COORD_WIDTH + GUARD + 4 > 33) ?
	                                (COORD_WIDTH + GUARD + 4) : 33;
	localparam int MHI_W          = CORD_W - 32;
	localparam int PHI_W          = MHI_W + 32;
	localparam int P_W            = PHI_W + 1;
	localparam int R_W            = P_W - GUARD;
	localparam int RV_W           = R_W + 1;
	localparam int SUM_W          = RV_W + 1;
	localparam int IN_BITS        = 4 * COORD_WIDTH + ANGLE_W;
	localparam int IN_W           = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS       = 2 * COORD_WIDTH;
	localparam int OUT_W          = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [OFF_W-1:0]       offset_t;
	typedef logic signed [CORD_W-1:0]      wide_t;
	typedef logic signed [Z_W-1:0]         angle_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} quad_t;

	typedef struct packed {
		coord_t cx;
		coord_t cy;
	} center_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic angle_t atan_entry(input int i);
		angle_t a;
		case (i)
			0:  a = 32'sd536870912;
			1:  a = 32'sd316933406;
			2:  a = 32'sd167458907;
			3:  a = 32'sd85004756;
			4:  a = 32'sd42667331;
			5:  a = 32'sd21354465;
			6:  a = 32'sd10680862;
			7:  a = 32'sd5340245;
			8:  a = 32'sd2670163;
			9:  a = 32'sd1335087;
			10: a = 32'sd667544;
			11: a = 32'sd333772;
			12: a = 32'sd166886;
			13: a = 32'sd83443;
			14: a = 32'sd41722;
			15: a = 32'sd20861;
			16: a = 32'sd10430;
			17: a = 32'sd5215;
			18: a = 32'sd2608;
			19: a = 32'sd1304;
			20: a = 32'sd652;
			21: a = 32'sd326;
			22: a = 32'sd163;
			23: a = 32'sd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

/* sv/prac_cordic.sv */
// Rotation-mode CORDIC, one iteration per pipeline stage.
module prac_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  prac_pkg::wide_t   in_x,
	input  prac_pkg::wide_t   in_y,
	input  prac_pkg::angle_t  in_z,
	input  prac_pkg::center_t in_c,
	output logic              out_valid,
	input  logic              out_ready,
	output prac_pkg::wide_t   out_x,
	output prac_pkg::wide_t   out_y,
	output prac_pkg::center_t out_c
);
	import prac_pkg::*;

	localparam int N = ROTATION_STEPS;
	localparam angle_t ZLIM = angle_t'(2 * atan_entry(N - 1));

	logic    v_s [N];
	wide_t   x_s [N];
	wide_t   y_s [N];
	angle_t  z_s [N];
	center_t c_s [N];

	logic    rdy   [N+1];
	logic    src_v [N];
	wide_t   src_x [N];
	wide_t   src_y [N];
	angle_t  src_z [N];
	center_t src_c [N];

	assign rdy[N]   = out_ready;
	assign in_ready = rdy[0];

	assign src_v[0] = in_valid;
	assign src_x[0] = in_x;
	assign src_y[0] = in_y;
	assign src_z[0] = in_z;
	assign src_c[0] = in_c;

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_iter
			localparam angle_t ATAN = atan_entry(k);
			wide_t xs;
			wide_t ys;
			logic  pos;

			if (k > 0) begin : g_link
				assign src_v[k] = v_s[k-1];
				assign src_x[k] = x_s[k-1];
				assign src_y[k] = y_s[k-1];
				assign src_z[k] = z_s[k-1];
				assign src_c[k] = c_s[k-1];
			end

			assign rdy[k] = !v_s[k] || rdy[k+1];
			assign xs     = src_x[k] >>> k;
			assign ys     = src_y[k] >>> k;
			assign pos    = !src_z[k][Z_W-1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					v_s[k] <= src_v[k];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && src_v[k]) begin
					if (pos) begin
						x_s[k] <= src_x[k] - ys;
						y_s[k] <= src_y[k] + xs;
						z_s[k] <= src_z[k] - ATAN;
					end else begin
						x_s[k] <= src_x[k] + ys;
						y_s[k] <= src_y[k] - xs;
						z_s[k] <= src_z[k] + ATAN;
					end
					c_s[k] <= src_c[k];
				end
			end
		end
	endgenerate

	assign out_valid = v_s[N-1];
	assign out_x     = x_s[N-1];
	assign out_y     = y_s[N-1];
	assign out_c     = c_s[N-1];

	a_residual_converged: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N-1] |-> (z_s[N-1] <= ZLIM && z_s[N-1] >= -ZLIM))
		else $error("residual angle did not converge");

endmodule

/* sv/prac_gain.sv */
// Gain correction, rounding, centre offset and saturation.
module prac_gain (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  prac_pkg::wide_t   in_x,
	input  prac_pkg::wide_t   in_y,
	input  prac_pkg::center_t in_c,
	output logic              out_valid,
	input  logic              out_ready,
	output prac_pkg::coord_t  rotated_x,
	output prac_pkg::coord_t  rotated_y,
	output logic              clipped
);
	import prac_pkg::*;

	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
	localparam logic [P_W-1:0] HALF = P_W'(1) << (GUARD - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic                     neg_s1 [2];
	logic [CORD_W-1:0]        mag_s1 [2];
	center_t                  c_s1;
	logic                     neg_s2 [2];
	logic [PHI_W-1:0]         phi_s2 [2];
	logic [31:0]              plo_s2 [2];
	center_t                  c_s2;
	logic signed [RV_W-1:0]   rv_s3  [2];
	center_t                  c_s3;
	coord_t                   rx_s4, ry_s4;
	logic                     clip_s4;

	wide_t                    src [2];
	logic [63:0]              lo_full [2];
	logic [P_W-1:0]           psum [2];
	logic [R_W-1:0]           rnd  [2];
	logic signed [SUM_W-1:0]  sum  [2];
	coord_t                   sat  [2];
	logic                     hit  [2];

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign src[0] = in_x;
	assign src[1] = in_y;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			lo_full[l] = {32'h0, mag_s1[l][31:0]} * {32'h0, GAIN_Q32};
			psum[l]    = P_W'(phi_s2[l]) + P_W'(plo_s2[l]);
			rnd[l]     = R_W'((psum[l] + HALF) >> GUARD);
		end
		sum[0] = SUM_W'(rv_s3[0]) + SUM_W'(c_s3.cx);
		sum[1] = SUM_W'(rv_s3[1]) + SUM_W'(c_s3.cy);
		for (int l = 0; l < 2; l++) begin
			if (sum[l] > SAT_HI) begin
				sat[l] = COORD_MAX;
				hit[l] = 1'b1;
			end else if (sum[l] < SAT_LO) begin
				sat[l] = COORD_MIN;
				hit[l] = 1'b1;
			end else begin
				sat[l] = sum[l][COORD_WIDTH-1:0];
				hit[l] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int l = 0; l < 2; l++) begin
				neg_s1[l] <= src[l][CORD_W-1];
				mag_s1[l] <= src[l][CORD_W-1] ? CORD_W'(-src[l]) : CORD_W'(src[l]);
			end
			c_s1 <= in_c;
		end
		if (rdy2 && v_s1) begin
			for (int l = 0; l < 2; l++) begin
				neg_s2[l] <= neg_s1[l];
				phi_s2[l] <= PHI_W'(mag_s1[l][CORD_W-1:32]) * PHI_W'(GAIN_Q32);
				plo_s2[l] <= lo_full[l][63:32];
			end
			c_s2 <= c_s1;
		end
		if (rdy3 && v_s2) begin
			for (int l = 0; l < 2; l++) begin
				rv_s3[l] <= neg_s2[l] ? -$signed({1'b0, rnd[l]}) : $signed({1'b0, rnd[l]});
			end
			c_s3 <= c_s2;
		end
		if (rdy4 && v_s3) begin
			rx_s4   <= sat[0];
			ry_s4   <= sat[1];
			clip_s4 <= hit[0] || hit[1];
		end
	end

	assign out_valid = v_s4;
	assign rotated_x = rx_s4;
	assign rotated_y = ry_s4;
	assign clipped   = clip_s4;

endmodule

/* sv/point_rotate_about_center.sv */
// Top level: rotates a point about a centre by a binary angle.
//
// Input channel s_*: one word per point, fields point_x, point_y, center_x,
// center_y (signed, 8 fraction bits) and turn_angle (65536 per full turn).
// Output channel m_*: rotated_x and rotated_y in tdata, clipped in tuser.
// Exactly one output word is produced for every input word, in order.
// Throughput is one word per cycle while m_tready is high. An accepted word
// passes through one offset and quarter-turn stage, one stage per CORDIC
// iteration, then four stages for magnitude, gain multiply, rounding and
// centre offset with saturation, after which m_tvalid rises for it.
// Every stage has its own valid bit, so bubbles are squeezed out and input
// is still accepted while a finished word waits at the output.
// When m_tready is low the pipeline fills and then s_tready drops; nothing
// is lost or repeated. Reset clears all valid bits, so the block comes out
// of reset empty with m_tvalid low; data registers are not reset.
module point_rotate_about_center (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// point_x, point_y, center_x, center_y, turn_angle
	input  logic [prac_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// rotated_x, rotated_y
	output logic [prac_pkg::OUT_W-1:0]    m_tdata,
	// clipped
	output logic                          m_tuser
);
	import prac_pkg::*;

	localparam int CW = COORD_WIDTH;

	coord_t                 point_x, point_y;
	center_t                cin;
	logic [ANGLE_W-1:0]     turn_angle, theta, tq;
	logic signed [13:0]     zres;
	offset_t                dx, dy, rx, ry;
	quad_t                  quad;

	logic                   v_s1, rdy_s1;
	wide_t                  x_s1, y_s1;
	angle_t                 z_s1;
	center_t                c_s1;

	logic                   cor_ready, cor_valid, gain_ready;
	wide_t                  cor_x, cor_y;
	center_t                cor_c;
	coord_t                 rotated_x, rotated_y;
	logic                   clipped;

	assign point_x    = s_tdata[CW-1:0];
	assign point_y    = s_tdata[2*CW-1:CW];
	assign cin.cx     = s_tdata[3*CW-1:2*CW];
	assign cin.cy     = s_tdata[4*CW-1:3*CW];
	assign turn_angle = s_tdata[4*CW+ANGLE_W-1:4*CW];

	assign theta = ANGLE_W'(0) - turn_angle;
	assign tq    = theta + 16'h2000;
	assign quad  = quad_t'(tq[15:14]);
	assign zres  = {~tq[13], tq[12:0]};
	assign dx    = offset_t'(point_x) - offset_t'(cin.cx);
	assign dy    = offset_t'(point_y) - offset_t'(cin.cy);

	always_comb begin
		case (quad)
			QUAD_90: begin
				rx = -dy;
				ry = dx;
			end
			QUAD_180: begin
				rx = -dx;
				ry = -dy;
			end
			QUAD_270: begin
				rx = dy;
				ry = -dx;
			end
			default: begin
				rx = dx;
				ry = dy;
			end
		endcase
	end

	assign rdy_s1   = !v_s1 || cor_ready;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			x_s1 <= wide_t'(rx) <<< GUARD;
			y_s1 <= wide_t'(ry) <<< GUARD;
			z_s1 <= {{2{zres[13]}}, zres, 16'h0000};
			c_s1 <= cin;
		end
	end

	prac_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (cor_ready),
		.in_x      (x_s1),
		.in_y      (y_s1),
		.in_z      (z_s1),
		.in_c      (c_s1),
		.out_valid (cor_valid),
		.out_ready (gain_ready),
		.out_x     (cor_x),
		.out_y     (cor_y),
		.out_c     (cor_c)
	);

	prac_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cor_valid),
		.in_ready  (gain_ready),
		.in_x      (cor_x),
		.in_y      (cor_y),
		.in_c      (cor_c),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.rotated_x (rotated_x),
		.rotated_y (rotated_y),
		.clipped   (clipped)
	);

	assign m_tdata = OUT_W'({rotated_y, rotated_x});
	assign m_tuser = clipped;

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is ready");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted word missing from first stage");

	a_clip_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && rotated_x != COORD_MAX && rotated_x != COORD_MIN &&
		rotated_y != COORD_MAX && rotated_y != COORD_MIN |-> !clipped)
		else $error("clipped set on a result inside range");

endmodule

/* bench/tb_point_rotate_about_center.sv */
// Testbench for point_rotate_about_center: streams points, predicts each rotation and checks it.
`timescale 1ns / 100ps

module tb_point_rotate_about_center;
	import prac_pkg::*;

	localparam int CW           = COORD_WIDTH;
	localparam int FRAC_GUARD   = 16;
	localparam int ARCTAN_COUNT = 24;
	localparam int CORDIC_ITERS = (ROTATION_STEPS > ARCTAN_COUNT) ? ARCTAN_COUNT :
	                              ((ROTATION_STEPS < 0) ? 0 : ROTATION_STEPS);
	localparam longint unsigned GAIN_FACTOR = 64'h9B74EDA8;

	typedef struct packed {
		logic   clip;
		coord_t y;
		coord_t x;
	} rot_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tuser;

	longint arctan_turn32 [0:ARCTAN_COUNT-1] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10680862, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	rot_result_t rotated_due_q [$];
	int          mismatch_count;
	bit          gaps_on;
	int          max_gap;
	int          max_burst;
	int          burst_left;
	int          stall_pct;
	bit          hold_off_req;
	int          hold_left;

	point_rotate_about_center dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic longint scale_by_gain(input longint v);
		logic            neg;
		longint unsigned m;
		longint unsigned p;
		neg = v < 0;
		m = neg ? longint'(-v) : longint'(v);
		p = (m >> 32) * GAIN_FACTOR + (((m & 64'hFFFF_FFFF) * GAIN_FACTOR) >> 32);
		p = (p + (64'd1 << (FRAC_GUARD - 1))) >> FRAC_GUARD;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic coord_t clamp_coord(input longint v, inout logic hit);
		if (v > longint'(COORD_MAX)) begin
			hit = 1'b1;
			return COORD_MAX;
		end
		if (v < longint'(COORD_MIN)) begin
			hit = 1'b1;
			return COORD_MIN;
		end
		return coord_t'(v);
	endfunction

	function automatic rot_result_t rotate_about_center(input coord_t px, input coord_t py,
	                                                    input coord_t cx, input coord_t cy,
	                                                    input logic [ANGLE_W-1:0] ang);
		logic [15:0] theta;
		logic [15:0] shifted;
		quad_t       q;
		longint      dx, dy, x, y, z, xs, ys, t;
		logic        hit;
		rot_result_t r;
		theta   = 16'd0 - ang;
		shifted = theta + 16'h2000;
		q       = quad_t'(shifted[15:14]);
		z       = (longint'(shifted[13:0]) - 8192) * 65536;
		dx      = longint'(px) - longint'(cx);
		dy      = longint'(py) - longint'(cy);
		case (q)
			QUAD_90: begin
				x = -dy;
				y = dx;
			end
			QUAD_180: begin
				x = -dx;
				y = -dy;
			end
			QUAD_270: begin
				x = dy;
				y = -dx;
			end
			default: begin
				x = dx;
				y = dy;
			end
		endcase
		x = x * (longint'(1) << FRAC_GUARD);
		y = y * (longint'(1) << FRAC_GUARD);
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				t = x - ys;
				y = y + xs;
				x = t;
				z = z - arctan_turn32[i];
			end else begin
				t = x + ys;
				y = y - xs;
				x = t;
				z = z + arctan_turn32[i];
			end
		end
		hit    = 1'b0;
		r.x    = clamp_coord(scale_by_gain(x) + longint'(cx), hit);
		r.y    = clamp_coord(scale_by_gain(y) + longint'(cy), hit);
		r.clip = hit;
		return r;
	endfunction

	task automatic send_point(input coord_t px, input coord_t py, input coord_t cx,
	                          input coord_t cy, input logic [ANGLE_W-1:0] ang);
		int              gap;
		logic [IN_W-1:0] word;
		rot_result_t     due_word;
		gap = 0;
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, max_gap);
				burst_left = $urandom_range(1, max_burst);
			end
			burst_left--;
		end
		word = '0;
		word[4*CW+ANGLE_W-1:0] = {ang, cy, cx, py, px};
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		due_word      = rotate_about_center(px, py, cx, cy, ang);
		rotated_due_q = {rotated_due_q, due_word};
	endtask

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 3))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return coord_t'(0);
			default: return coord_t'(-1);
		endcase
	endfunction

	task automatic send_random_point();
		coord_t          px, py, cx, cy;
		logic [15:0]     ang;
		int unsigned     mode;
		mode = $urandom_range(0, 9);
		if (mode <= 2) begin
			px = coord_t'($urandom);
			py = coord_t'($urandom);
			cx = coord_t'($urandom);
			cy = coord_t'($urandom);
		end else if (mode <= 5) begin
			cx = coord_t'($urandom);
			cy = coord_t'($urandom);
			px = coord_t'(cx + coord_t'(int'($urandom_range(0, 8191)) - 4096));
			py = coord_t'(cy + coord_t'(int'($urandom_range(0, 8191)) - 4096));
		end else if (mode <= 7) begin
			px = coord_t'(int'($urandom_range(0, 131071)) - 65536);
			py = coord_t'(int'($urandom_range(0, 131071)) - 65536);
			cx = coord_t'(int'($urandom_range(0, 131071)) - 65536);
			cy = coord_t'(int'($urandom_range(0, 131071)) - 65536);
		end else if (mode == 8) begin
			px = pick_extreme();
			py = pick_extreme();
			cx = pick_extreme();
			cy = pick_extreme();
		end else begin
			cx = coord_t'($urandom);
			cy = coord_t'($urandom);
			px = cx;
			py = cy;
		end
		if ($urandom_range(0, 7) == 0)
			ang = 16'($urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 2) - 1);
		else
			ang = 16'($urandom_range(0, 65535));
		send_point(px, py, cx, cy, ang);
	endtask

	task automatic test_field_extremes();
		gaps_on   = 1'b0;
		stall_pct = 0;
		send_point('0, '0, '0, '0, 16'h0000);
		send_point(COORD_MAX, COORD_MIN, '0, '0, 16'h0000);
		send_point(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 16'h4000);
		send_point(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'h8000);
		send_point(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 16'hFFFF);
		send_point(coord_t'(-1), coord_t'(-1), coord_t'(1), coord_t'(1), 16'h0001);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'hC000);
	endtask

	task automatic test_quadrant_edges();
		logic [15:0] edges [0:9];
		edges = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000, 16'h6000,
		          16'h8000, 16'hA000, 16'hC000, 16'hE000, 16'hE001};
		gaps_on   = 1'b1;
		stall_pct = 20;
		foreach (edges[k])
			send_point(coord_t'(24'h012345), coord_t'(-24'sd70000), coord_t'(24'h000800),
			           coord_t'(24'h001000), edges[k]);
	endtask

	task automatic test_saturation();
		gaps_on   = 1'b0;
		stall_pct = 40;
		send_point(COORD_MAX, '0, coord_t'(COORD_MAX - 25600), '0, 16'h0000);
		send_point('0, COORD_MIN, '0, coord_t'(COORD_MIN + 25600), 16'h0000);
		send_point(COORD_MAX, COORD_MAX, '0, '0, 16'h2000);
		send_point(COORD_MIN, COORD_MIN, '0, '0, 16'hE000);
		send_point(COORD_MIN, '0, COORD_MAX, '0, 16'h8000);
	endtask

	task automatic test_random_stream(input int count, input bit gaps, input int stall);
		gaps_on    = gaps;
		burst_left = 0;
		stall_pct  = stall;
		repeat (count) send_random_point();
	endtask

	task automatic test_backpressure_fill(input int count);
		gaps_on      = 1'b0;
		stall_pct    = 0;
		hold_off_req = 1'b1;
		repeat (count) send_random_point();
	endtask

	// receiver: random stalls, plus one long hold when asked
	initial begin
		m_tready  = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = 300;
				m_tready    <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_rotation
		rot_result_t due;
		coord_t      got_x;
		coord_t      got_y;
		if (arst_n && m_tvalid && m_tready) begin
			got_x = m_tdata[CW-1:0];
			got_y = m_tdata[2*CW-1:CW];
			if (rotated_due_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: x=%0d y=%0d clipped=%0b",
					         got_x, got_y, m_tuser);
			end else begin
				due = rotated_due_q.pop_front();
				if (got_x !== due.x || got_y !== due.y || m_tuser !== due.clip) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: expected x=%0d y=%0d clipped=%0b, ",
						          "got x=%0d y=%0d clipped=%0b"},
						         due.x, due.y, due.clip, got_x, got_y, m_tuser);
				end
			end
		end
	end

	initial begin
		int drain_cycles;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		mismatch_count = 0;
		gaps_on        = 1'b0;
		max_gap        = 6;
		max_burst      = 12;
		burst_left     = 0;
		stall_pct      = 0;
		hold_off_req   = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_quadrant_edges();
		test_saturation();
		test_random_stream(250, 1'b1, 30);
		test_random_stream(250, 1'b0, 0);
		test_random_stream(250, 1'b1, 60);
		test_random_stream(250, 1'b0, 50);
		test_backpressure_fill(150);

		@(negedge clk);
		s_tvalid <= 1'b0;
		drain_cycles = 0;
		while (rotated_due_q.size() > 0 && drain_cycles < 5000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (ROTATION_STEPS + 10) @(posedge clk);
		mismatch_count += rotated_due_q.size();

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* point_rotate_about_center.f */
sv/prac_pkg.sv
sv/prac_cordic.sv
sv/prac_gain.sv
sv/point_rotate_about_center.sv
bench/tb_point_rotate_about_center.sv
